@@ rtl/core/rotation_matrix_to_quaternion_top_macros.svh @@
// ----------------------------------------------------------------------------
// rotation matrix to quaternion: assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define RMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rmq assertion failed");
// condition must never be seen at a clock edge outside reset
`define RMQ_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rmq forbidden condition seen");
`else
`define RMQ_ASSERT(lbl, clk, rstn, prop)
`define RMQ_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ rtl/core/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// beat types, classification record and fixed constants of the converter
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int D_W         = 17;  // signed sum or difference of two elements
  localparam int Q_W         = 17;  // quotient magnitude bits before saturation
  localparam int OUT_W       = 16;
  localparam int LANES       = 3;   // components produced by division
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [OUT_W-1:0] Q_POS_MAX = 16'h7fff;
  localparam logic [OUT_W-1:0] Q_NEG_MIN = 16'h8000;

  // quaternion slot that receives the half root
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2,
    AX_W = 2'd3
  } axis_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] corner;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               invalid;
  } out_beat_t;

  // da, db, dc go to the three non-half slots in ascending slot order
  typedef struct packed {
    logic                  invalid;
    axis_t                 half_axis;
    logic signed [D_W-1:0] da;
    logic signed [D_W-1:0] db;
    logic signed [D_W-1:0] dc;
  } cls_t;

  typedef struct packed {
    logic             invalid;
    axis_t            half_axis;
    logic [LANES-1:0] neg;
    logic [OUT_W-1:0] half;
  } div_sb_t;

endpackage

@@ rtl/core/rmq_in_if.sv @@
// ----------------------------------------------------------------------------
// rmq_in_if
// matrix input channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic               valid;
  logic               ready;
  rmq_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rmq_out_if.sv @@
// ----------------------------------------------------------------------------
// rmq_out_if
// quaternion result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rmq_out_if;
  logic               valid;
  logic               ready;
  rmq_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// picks the trace or diagonal branch, forms the radicand and the numerators
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int RAD_W     = 19
) (
  input  rmq_pkg::in_beat_t beat_i,
  output rmq_pkg::cls_t     cls_o,
  output logic [RAD_W-1:0]  rad_o
);

  localparam int RSW = RAD_W + 1;
  localparam int DW  = rmq_pkg::D_W;

  logic signed [RSW-1:0] e00, e11, e22, trace, rad_s, one;
  logic signed [DW-1:0]  s01, s02, s12, d12, d20, d01;
  rmq_pkg::axis_t        ax;
  logic                  trace_pos;
  logic                  bad;

  assign e00 = RSW'(beat_i.m00);
  assign e11 = RSW'(beat_i.m11);
  assign e22 = RSW'(beat_i.m22);
  assign one = RSW'(1) << FRAC_BITS;

  assign s01 = DW'(beat_i.m01) + DW'(beat_i.m10);
  assign s02 = DW'(beat_i.m02) + DW'(beat_i.m20);
  assign s12 = DW'(beat_i.m12) + DW'(beat_i.m21);
  assign d12 = DW'(beat_i.m12) - DW'(beat_i.m21);
  assign d20 = DW'(beat_i.m20) - DW'(beat_i.m02);
  assign d01 = DW'(beat_i.m01) - DW'(beat_i.m10);

  assign trace     = e00 + e11 + e22;
  assign trace_pos = !trace[RSW-1] && (trace != '0);

  // largest diagonal, lower index wins ties
  always_comb begin
    ax = rmq_pkg::AX_X;
    if (beat_i.m11 > beat_i.m00) ax = rmq_pkg::AX_Y;
    if (beat_i.m22 > ((ax == rmq_pkg::AX_Y) ? beat_i.m11 : beat_i.m00)) ax = rmq_pkg::AX_Z;
  end

  always_comb begin
    cls_o = '0;
    if (trace_pos) begin
      rad_s           = trace + RSW'(beat_i.corner);
      cls_o.half_axis = rmq_pkg::AX_W;
      cls_o.da        = d12;
      cls_o.db        = d20;
      cls_o.dc        = d01;
    end else begin
      cls_o.half_axis = ax;
      case (ax)
        rmq_pkg::AX_X: begin
          rad_s    = e00 - (e11 + e22) + one;
          cls_o.da = s01;
          cls_o.db = s02;
          cls_o.dc = d12;
        end
        rmq_pkg::AX_Y: begin
          rad_s    = e11 - (e22 + e00) + one;
          cls_o.da = s01;
          cls_o.db = s12;
          cls_o.dc = d20;
        end
        default: begin
          rad_s    = e22 - (e00 + e11) + one;
          cls_o.da = s02;
          cls_o.db = s12;
          cls_o.dc = d01;
        end
      endcase
    end
    bad           = rad_s[RSW-1] || (rad_s == '0);
    cls_o.invalid = bad;
    rad_o         = bad ? RAD_W'(1) : rad_s[RAD_W-1:0];
  end

endmodule

@@ rtl/core/rmq_queue.sv @@
// ----------------------------------------------------------------------------
// rmq_queue
// small fifo between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
module rmq_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         empty_o
);

  localparam int PW = rmq_pkg::QPTR_W;

  logic [W-1:0]  mem_r [rmq_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == (PW+1)'(rmq_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign dout_o  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push_i ? wr_r + PW'(1) : wr_r;
    rd_nxt  = pop_i ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_r] <= din_i;
  end

endmodule

@@ rtl/core/rmq_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
  parameter int X_W  = 33,
  parameter int RT_W = 17,
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [X_W-1:0]  x_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            vld_o,
  output logic [RT_W-1:0] root_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int TW = 2 * RT_W + 1;

  logic [X_W-1:0]  rem_r [RT_W];
  logic [RT_W-1:0] res_r [RT_W];
  logic [SB_W-1:0] sb_r  [RT_W];
  logic [RT_W-1:0] vld_r;

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    localparam int B = RT_W - 1 - s;
    logic [X_W-1:0]  rem_in;
    logic [RT_W-1:0] res_in;
    logic [SB_W-1:0] sb_in;
    logic            vld_in;
    logic [TW-1:0]   trial;
    logic            take;

    if (s == 0) begin : g_first
      assign rem_in = x_i;
      assign res_in = '0;
      assign sb_in  = sb_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign res_in = res_r[s-1];
      assign sb_in  = sb_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    // (2*res + 2^b) * 2^b is what setting bit b adds to the square
    assign trial = (TW'(res_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = (TW'(rem_in) >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en_i) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[s] <= take ? X_W'(TW'(rem_in) - trial) : rem_in;
        res_r[s] <= take ? (res_in | (RT_W'(1) << B)) : res_in;
        sb_r[s]  <= sb_in;
      end
    end
  end

  assign vld_o  = vld_r[RT_W-1];
  assign root_o = res_r[RT_W-1];
  assign sb_o   = sb_r[RT_W-1];

endmodule

@@ rtl/core/rmq_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rmq_div_pipe
// three restoring dividers sharing one divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 18,
  parameter int SB_W  = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en_i,
  input  logic                                         vld_i,
  input  logic [rmq_pkg::LANES-1:0][NUM_W-1:0]         num_i,
  input  logic [DEN_W-1:0]                             den_i,
  input  logic [SB_W-1:0]                              sb_i,
  output logic                                         vld_o,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::Q_W-1:0]  quo_o,
  output logic [rmq_pkg::LANES-1:0]                    ovf_o,
  output logic [SB_W-1:0]                              sb_o
);

  localparam int L     = rmq_pkg::LANES;
  localparam int QW    = rmq_pkg::Q_W;
  localparam int CMP_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic [L-1:0][NUM_W-1:0] rem_r [QW+1];
  logic [L-1:0][QW-1:0]    quo_r [QW+1];
  logic [L-1:0]            ovf_r [QW+1];
  logic [DEN_W-1:0]        den_r [QW+1];
  logic [SB_W-1:0]         sb_r  [QW+1];
  logic [QW:0]             vld_r;
  logic [L-1:0]            ovf_in;

  // quotient needs more than QW bits
  for (genvar l = 0; l < L; l++) begin : g_ovf
    assign ovf_in[l] = (CMP_W'(num_i[l] >> QW) >= CMP_W'(den_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en_i) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r[0] <= num_i;
      quo_r[0] <= '0;
      ovf_r[0] <= ovf_in;
      den_r[0] <= den_i;
      sb_r[0]  <= sb_i;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int B = QW - s;
    logic [L-1:0][NUM_W-1:0] rem_nxt;
    logic [L-1:0][QW-1:0]    quo_nxt;
    logic [CMP_W-1:0]        trial;

    assign trial = CMP_W'(den_r[s-1]) << B;

    for (genvar l = 0; l < L; l++) begin : g_lane
      logic take;
      assign take       = (CMP_W'(rem_r[s-1][l]) >= trial);
      assign rem_nxt[l] = take ? NUM_W'(CMP_W'(rem_r[s-1][l]) - trial) : rem_r[s-1][l];
      assign quo_nxt[l] = take ? (quo_r[s-1][l] | (QW'(1) << B)) : quo_r[s-1][l];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en_i) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        ovf_r[s] <= ovf_r[s-1];
        den_r[s] <= den_r[s-1];
        sb_r[s]  <= sb_r[s-1];
      end
    end
  end

  assign vld_o = vld_r[QW];
  assign quo_o = quo_r[QW];
  assign ovf_o = ovf_r[QW];
  assign sb_o  = sb_r[QW];

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shepperd conversion of a fixed-point rotation matrix to a quaternion
// ----------------------------------------------------------------------------
// One beat in carries the nine rotation elements and the homogeneous corner
// element, signed with FRAC_BITS fraction bits; one beat out carries qx, qy,
// qz, qw in the same format plus an invalid flag (components zero when the
// radicand is not positive). A new matrix can be taken every cycle and one
// quaternion leaves every cycle while the sink keeps up. From input beat to
// output beat a matrix passes through the input queue, ROOT_W =
// ceil((RAD_W + FRAC_BITS) / 2) square root stages, 18 divider stages and
// the output register. The square root and divider pipelines advance
// together and stall only when the output register holds an untaken beat;
// the four-entry queue in front keeps accepting until it fills. The block
// holds no state between matrices.
`include "rotation_matrix_to_quaternion_top_macros.svh"

module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);

  // radicand magnitude bound: 4 * 2^15 on the trace branch, 2^FRAC_BITS + 3 * 2^15 else
  localparam int RAD_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int X_W    = RAD_W + FRAC_BITS;
  localparam int ROOT_W = (X_W + 1) / 2;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int NUM_W  = rmq_pkg::D_W + FRAC_BITS;
  localparam int HALF_W = (ROOT_W > 17) ? ROOT_W : 17;
  localparam int CLS_W  = $bits(rmq_pkg::cls_t);
  localparam int SB_W   = $bits(rmq_pkg::div_sb_t);
  localparam int QD_W   = CLS_W + RAD_W;
  localparam int L      = rmq_pkg::LANES;
  localparam int QW     = rmq_pkg::Q_W;
  localparam int OW     = rmq_pkg::OUT_W;

  // front: classify straight into the queue
  rmq_pkg::cls_t    f_cls;
  logic [RAD_W-1:0] f_rad;
  logic             q_full, q_empty, q_push, q_pop;
  logic [QD_W-1:0]  q_dout;

  rmq_front #(
    .FRAC_BITS (FRAC_BITS),
    .RAD_W     (RAD_W)
  ) u_front (
    .beat_i (in_ch.data),
    .cls_o  (f_cls),
    .rad_o  (f_rad)
  );

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  rmq_queue #(
    .W (QD_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .din_i   ({f_cls, f_rad}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty)
  );

  // back: whole pipeline moves when the output register can take a beat
  logic              out_vld_r;
  rmq_pkg::out_beat_t out_beat_r, out_beat_nxt;
  logic              en;

  assign en    = !out_vld_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  logic             sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [CLS_W-1:0] sq_sb;

  rmq_sqrt_pipe #(
    .X_W  (X_W),
    .RT_W (ROOT_W),
    .SB_W (CLS_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (en),
    .vld_i  (!q_empty),
    .x_i    (X_W'(q_dout[RAD_W-1:0]) << FRAC_BITS),
    .sb_i   (q_dout[QD_W-1:RAD_W]),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  // numerators as magnitudes, signs ride along in the sideband
  rmq_pkg::cls_t                     sq_cls;
  logic [L-1:0][rmq_pkg::D_W-1:0]    d_s;
  logic [L-1:0][NUM_W-1:0]           num;
  logic [HALF_W-1:0]                 half_ext;
  rmq_pkg::div_sb_t                  dv_sb_in;

  assign sq_cls   = rmq_pkg::cls_t'(sq_sb);
  assign d_s[0]   = sq_cls.da;
  assign d_s[1]   = sq_cls.db;
  assign d_s[2]   = sq_cls.dc;
  assign half_ext = HALF_W'(sq_root >> 1);

  always_comb begin
    dv_sb_in.invalid   = sq_cls.invalid;
    dv_sb_in.half_axis = sq_cls.half_axis;
    dv_sb_in.half      = (half_ext > HALF_W'(32767)) ? rmq_pkg::Q_POS_MAX : half_ext[OW-1:0];
    for (int l = 0; l < L; l++) begin
      dv_sb_in.neg[l] = d_s[l][rmq_pkg::D_W-1];
      // -(-65536) wraps to the right unsigned magnitude in 17 bits
      num[l] = NUM_W'(d_s[l][rmq_pkg::D_W-1] ? (rmq_pkg::D_W)'(-d_s[l]) : d_s[l])
               << FRAC_BITS;
    end
  end

  logic                 dv_vld;
  logic [L-1:0][QW-1:0] dv_quo;
  logic [L-1:0]         dv_ovf;
  logic [SB_W-1:0]      dv_sb;

  rmq_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SB_W  (SB_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en_i  (en),
    .vld_i (sq_vld),
    .num_i (num),
    .den_i ({sq_root, 1'b0}),
    .sb_i  (dv_sb_in),
    .vld_o (dv_vld),
    .quo_o (dv_quo),
    .ovf_o (dv_ovf),
    .sb_o  (dv_sb)
  );

  // saturate each quotient, then drop the half root into its slot
  rmq_pkg::div_sb_t dv_info;
  logic [L-1:0][OW-1:0] comp;

  assign dv_info = rmq_pkg::div_sb_t'(dv_sb);

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (!dv_info.neg[l]) begin
        comp[l] = (dv_ovf[l] || dv_quo[l] > QW'(32767)) ? rmq_pkg::Q_POS_MAX
                                                        : dv_quo[l][OW-1:0];
      end else begin
        comp[l] = (dv_ovf[l] || dv_quo[l] > QW'(32768)) ? rmq_pkg::Q_NEG_MIN
                                                        : OW'(-dv_quo[l]);
      end
    end
    out_beat_nxt = '0;
    case (dv_info.half_axis)
      rmq_pkg::AX_X: begin
        out_beat_nxt.qx = dv_info.half;
        out_beat_nxt.qy = comp[0];
        out_beat_nxt.qz = comp[1];
        out_beat_nxt.qw = comp[2];
      end
      rmq_pkg::AX_Y: begin
        out_beat_nxt.qx = comp[0];
        out_beat_nxt.qy = dv_info.half;
        out_beat_nxt.qz = comp[1];
        out_beat_nxt.qw = comp[2];
      end
      rmq_pkg::AX_Z: begin
        out_beat_nxt.qx = comp[0];
        out_beat_nxt.qy = comp[1];
        out_beat_nxt.qz = dv_info.half;
        out_beat_nxt.qw = comp[2];
      end
      default: begin
        out_beat_nxt.qx = comp[0];
        out_beat_nxt.qy = comp[1];
        out_beat_nxt.qz = comp[2];
        out_beat_nxt.qw = dv_info.half;
      end
    endcase
    if (dv_info.invalid) begin
      out_beat_nxt         = '0;
      out_beat_nxt.invalid = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_beat_r <= out_beat_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_beat_r;

  logic out_comp_zero;

  assign out_comp_zero = (out_beat_r.qx == '0) && (out_beat_r.qy == '0) &&
                         (out_beat_r.qz == '0) && (out_beat_r.qw == '0);

  // an invalid beat carries zero components
  `RMQ_ASSERT(a_invalid_zero, clk, rst_n, out_ch.valid && out_ch.data.invalid |-> out_comp_zero)
  // a stalled output freezes the back pipeline, so nothing leaves the queue
  `RMQ_NEVER(a_pop_on_stall, clk, rst_n, out_ch.valid && !out_ch.ready && q_pop)
  // a new output beat comes from a valid divider stage
  `RMQ_ASSERT(a_out_from_div, clk, rst_n, $rose(out_ch.valid) |-> $past(dv_vld))

endmodule

@@ dv/rmq_tb_if.sv @@
// ----------------------------------------------------------------------------
// rmq_tb_if
// shared testbench constants
// ----------------------------------------------------------------------------
// the block's own channel interfaces (rmq_in_if, rmq_out_if) are instantiated
// directly by the testbench top; this file only holds the watchdog limit
package rmq_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  localparam int WATCHDOG_LIMIT = 20000;
endpackage

@@ dv/rotation_matrix_to_quaternion_top_tb.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top_tb
// self-checking bench for the matrix to quaternion converter
// ----------------------------------------------------------------------------
// a directed table (extremes, diagonal ties, zero trace, bad radicands,
// saturation) runs first, then random matrices, mostly near-rotations with
// a share of raw noise; every result beat is compared with a local model
// of the Shepperd conversion, with random gaps on both channels
module rotation_matrix_to_quaternion_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam int N_RANDOM = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // directed row: matrix, whether an expected value is typed in, and that value
  typedef struct {
    rmq_pkg::in_beat_t  mat;
    bit                 fixed;
    rmq_pkg::out_beat_t want;
  } vec_t;

  rmq_pkg::out_beat_t quat_q[$];
  int                 n_fail = 0;
  int                 idle_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint isqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // trunc(d * 2^F / (2 * root)); SV division truncates toward zero
  function automatic logic signed [15:0] scaled(longint d, longint root);
    return clip16((d * (64'sd1 << FRAC)) / (2 * root));
  endfunction

  function automatic rmq_pkg::out_beat_t shepperd(rmq_pkg::in_beat_t a);
    longint m[3][3];
    longint q[4];
    longint tr, rad, root;
    int i, j, k;
    rmq_pkg::out_beat_t o;
    m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
    m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
    m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
    o = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rad = tr + longint'(a.corner);
      if (rad <= 0) begin
        o.invalid = 1'b1;
        return o;
      end
      root = isqrt(rad << FRAC);
      q[3] = clip16(root >>> 1);
      q[0] = scaled(m[1][2] - m[2][1], root);
      q[1] = scaled(m[2][0] - m[0][2], root);
      q[2] = scaled(m[0][1] - m[1][0], root);
    end else begin
      // strict compares: lower index wins a tie
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - (m[j][j] + m[k][k]) + (64'sd1 << FRAC);
      if (rad <= 0) begin
        o.invalid = 1'b1;
        return o;
      end
      root = isqrt(rad << FRAC);
      q[i] = clip16(root >>> 1);
      q[3] = scaled(m[j][k] - m[k][j], root);
      q[j] = scaled(m[i][j] + m[j][i], root);
      q[k] = scaled(m[i][k] + m[k][i], root);
    end
    o.qx = q[0][15:0];
    o.qy = q[1][15:0];
    o.qz = q[2][15:0];
    o.qw = q[3][15:0];
    return o;
  endfunction

  // directed rows carry a typed value; the lookup keeps one queue for both parts
  rmq_pkg::out_beat_t typed_map[rmq_pkg::in_beat_t];
  function automatic rmq_pkg::out_beat_t exp_of(rmq_pkg::in_beat_t a);
    rmq_pkg::out_beat_t p;
    p = shepperd(a);
    if (typed_map.exists(a)) begin
      if (typed_map[a] !== p) begin
        $error("typed row disagrees with model: %h", a);
        n_fail++;
      end
      return typed_map[a];
    end
    return p;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic rmq_pkg::in_beat_t mk(int d0, int d1, int d2, int off, int cn);
    rmq_pkg::in_beat_t a;
    a = '0;
    a.m00 = 16'(d0); a.m11 = 16'(d1); a.m22 = 16'(d2); a.corner = 16'(cn);
    a.m01 = 16'(off); a.m12 = 16'(-off); a.m20 = 16'(off);
    return a;
  endfunction

  function automatic rmq_pkg::in_beat_t noise_mat();
    rmq_pkg::in_beat_t a;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return a;
  endfunction

  function automatic logic [15:0] unit_rand();
    return 16'($urandom_range(32768) - 16384);
  endfunction

  // near-rotation: diagonal and off-diagonal around unit scale, corner mostly 1.0
  function automatic rmq_pkg::in_beat_t rot_mat();
    rmq_pkg::in_beat_t a;
    a.m00 = unit_rand();
    a.m11 = unit_rand();
    a.m22 = unit_rand();
    a.m01 = unit_rand();
    a.m02 = unit_rand();
    a.m10 = unit_rand();
    a.m12 = unit_rand();
    a.m20 = unit_rand();
    a.m21 = unit_rand();
    a.corner = ($urandom_range(7) == 0) ? 16'($urandom) : 16'sd16384;
    return a;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // pushes one beat; valid stays high across back-to-back beats
  task automatic send(rmq_pkg::in_beat_t a);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    rmq_pkg::out_beat_t got, exp_q;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (quat_q.size() == 0) begin
        $error("unexpected result beat %h", got);
        n_fail++;
      end else begin
        exp_q = quat_q.pop_front();
        if (got.qx !== exp_q.qx) begin
          $error("qx expected %0d actual %0d", exp_q.qx, got.qx); n_fail++;
        end
        if (got.qy !== exp_q.qy) begin
          $error("qy expected %0d actual %0d", exp_q.qy, got.qy); n_fail++;
        end
        if (got.qz !== exp_q.qz) begin
          $error("qz expected %0d actual %0d", exp_q.qz, got.qz); n_fail++;
        end
        if (got.qw !== exp_q.qw) begin
          $error("qw expected %0d actual %0d", exp_q.qw, got.qw); n_fail++;
        end
        if (got.invalid !== exp_q.invalid) begin
          $error("invalid expected %0d actual %0d", exp_q.invalid, got.invalid);
          n_fail++;
        end
      end
    end
  end

  // expectation enqueued at the accepting edge itself
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) quat_q.push_back(exp_of(in_ch.data));
  end

  // sink side: random stalls, some long, some stretches with none
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (gap_len() == 0);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= rmq_tb_pkg::WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    vec_t tbl[$];
    vec_t v;
    rmq_pkg::out_beat_t zero_bad;
    int n;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    zero_bad = '0;
    zero_bad.invalid = 1'b1;

    // identity: w = 1.0, rest zero
    v.mat = mk(16384, 16384, 16384, 0, 16384); v.fixed = 1;
    v.want = '{qx: 0, qy: 0, qz: 0, qw: 16384, invalid: 0}; tbl.push_back(v);
    // all zero: zero trace path, radicand 1.0 on x, half root 0.5
    v.mat = '0; v.want = '{qx: 8192, qy: 0, qz: 0, qw: 0, invalid: 0}; tbl.push_back(v);
    // positive trace with corner cancelling it: bad radicand
    v.mat = mk(1, 0, 0, 0, -1); v.want = zero_bad; tbl.push_back(v);
    // positive trace with the most negative corner: negative radicand
    v.mat = mk(100, 0, 0, 0, -32768); v.want = zero_bad; tbl.push_back(v);
    // most negative diagonal, no bad radicand: checked against the model
    v.fixed = 0;
    v.mat = mk(-32768, -32768, -32768, 0, 0); tbl.push_back(v);
    // diagonal ties and each axis winning
    v.mat = mk(-100, -100, -100, 3000, 0); tbl.push_back(v);
    v.mat = mk(-200, 100, -200, -3000, 0); tbl.push_back(v);
    v.mat = mk(-200, -300, 100, 5000, 0); tbl.push_back(v);
    v.mat = mk(-200, 100, 100, 7000, 0); tbl.push_back(v);
    // trace exactly zero
    v.mat = mk(16384, -16384, 0, 1234, 16384); tbl.push_back(v);
    // extremes: all max, all min, max corner, saturating off-diagonals
    v.mat = {10{16'sh7fff}}; tbl.push_back(v);
    v.mat = {10{16'sh8000}}; tbl.push_back(v);
    v.mat = mk(1, 0, 0, 32767, 32767); tbl.push_back(v);
    v.mat = mk(0, 0, 1, -32768, 0); v.mat.m21 = 16'sh7fff; tbl.push_back(v);
    v.mat = mk(-32768, 32767, -32768, -32768, 0); v.mat.m10 = 16'sh8000; tbl.push_back(v);

    foreach (tbl[t]) if (tbl[t].fixed) typed_map[tbl[t].mat] = tbl[t].want;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tbl[t]) send(tbl[t].mat);
    for (n = 0; n < N_RANDOM; n++) send(($urandom_range(4) == 0) ? noise_mat() : rot_mat());
    in_ch.valid <= 1'b0;

    // drain, then the pipeline latency again for stray beats
    while (quat_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
